/* rtl/ipuc_pkg.sv */
// Package for the IPv4 prefix utilization counter.
// Holds sizes, register indexes and result status codes.
// No dependencies.
package ipuc_pkg;

   localparam int SEEN_DEPTH   = 64;
   localparam int SEEN_AW      = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
   localparam int FILL_W       = $clog2(SEEN_DEPTH + 1);
   localparam int PREFIX_SLOTS = 6;

   localparam int ADDR_W  = 32;
   localparam int KIND_W  = 16;
   localparam int COUNT_W = 31;
   localparam int SLOT_W  = 3;
   localparam int LEN_W   = 6;
   localparam int CFG_W   = 38;
   localparam int IDX_W   = 3;
   localparam int STAT_W  = 3;
   localparam int RSP_W   = 72;

   localparam logic [KIND_W-1:0] ETHER_IPV4 = 16'h0800;
   localparam logic [LEN_W-1:0]  LEN_MIN    = 6'd1;
   localparam logic [LEN_W-1:0]  LEN_MAX    = 6'd30;

   localparam logic [IDX_W-1:0] CSR_TOTAL       = 3'd0;
   localparam logic [IDX_W-1:0] CSR_PREFIX_A    = 3'd1;
   localparam logic [IDX_W-1:0] CSR_PREFIX_LAST = 3'd6;

   localparam logic [STAT_W-1:0] STAT_NOT_IP    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_INVALID   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NO_MATCH  = 3'd4;
   localparam logic [STAT_W-1:0] STAT_COUNTED   = 3'd5;

endpackage

/* rtl/ip_prefix_utilization_counter.sv */
// Top level of the IPv4 prefix utilization counter.
// A rejected frame goes straight to its result; a duplicate ends its seen-table scan at the
// match, a full seen table ends it at the fill, and a new source goes on to the prefix match.
// One word at a time: the next word is accepted only after the result is taken and the
// block is back in idle; the one-entry-per-cycle seen-table scan sets the rate. Synchronous
// reset clears the counts, the table fill and the configuration to zero. Depends on ipuc_pkg.
module ip_prefix_utilization_counter
   import ipuc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [ADDR_W-1:0] req_tdata,  // [31:0] source_addr
   input  logic [KIND_W-1:0] req_tuser,  // [15:0] ether_kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [0] first_hit, [3:1] first_slot, [34:4] first_count, [35] first_half_warn,
   // [36] second_hit, [39:37] second_slot, [70:40] second_count, [71] second_half_warn
   output logic [RSP_W-1:0]  rsp_tdata,
   output logic [STAT_W-1:0] rsp_tuser,  // [2:0] status
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MATCH,
      ST_COUNT,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic [ADDR_W-1:0]    src_ff;
   logic [FILL_W-1:0]    fill_ff;
   logic [FILL_W-1:0]    scan_ff;
   logic                 cmp_vld_ff;
   logic [ADDR_W-1:0]    rd_data_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic                 phase2_ff;
   logic                 cnt_second_ff;
   logic [ADDR_W-1:0]    net1_ff;
   logic [LEN_W-1:0]     len1_ff;
   logic [LEN_W-1:0]     len2_ff;
   logic [SLOT_W-1:0]    total_ff;
   logic [CFG_W-1:0]     prefix_ff [PREFIX_SLOTS];
   logic [COUNT_W-1:0]   counts_ff [PREFIX_SLOTS];

   logic [STAT_W-1:0]    status_ff;
   logic                 hit1_ff;
   logic [SLOT_W-1:0]    slot1_ff;
   logic [COUNT_W-1:0]   count1_ff;
   logic                 warn1_ff;
   logic                 hit2_ff;
   logic [SLOT_W-1:0]    slot2_ff;
   logic [COUNT_W-1:0]   count2_ff;
   logic                 warn2_ff;

   logic [ADDR_W-1:0]    seen_mem [SEEN_DEPTH];
   logic                 mem_we;

   logic [SLOT_W-1:0]    total_lim;
   logic                 slot_in_range;
   logic [CFG_W-1:0]     cur_prefix;
   logic [LEN_W-1:0]     cur_len;
   logic                 cur_len_ok;
   logic [ADDR_W-1:0]    cur_mask;
   logic [ADDR_W-1:0]    cur_net;
   logic                 cur_match;
   logic                 cur_same;

   logic [SLOT_W-1:0]    cnt_slot;
   logic [LEN_W-1:0]     cnt_len;
   logic [COUNT_W-1:0]   cnt_cur;
   logic [COUNT_W-1:0]   cnt_inc;
   logic [ADDR_W-1:0]    cnt_cap;
   logic                 cnt_below;
   logic                 cnt_warn;
   logic [COUNT_W-1:0]   cnt_new;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign csr_ready  = 1'b1;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {warn2_ff, count2_ff, slot2_ff, hit2_ff,
                        warn1_ff, count1_ff, slot1_ff, hit1_ff};

   // Shared slot compare unit.
   assign total_lim     = (total_ff > SLOT_W'(PREFIX_SLOTS)) ? SLOT_W'(PREFIX_SLOTS) : total_ff;
   assign slot_in_range = (slot_ff < total_lim);
   assign cur_prefix    = slot_in_range ? prefix_ff[slot_ff] : '0;
   assign cur_len       = cur_prefix[CFG_W-1:ADDR_W];
   assign cur_len_ok    = (cur_len >= LEN_MIN) && (cur_len <= LEN_MAX);
   assign cur_mask      = {ADDR_W{1'b1}} << (LEN_W'(ADDR_W) - cur_len);
   assign cur_net       = cur_prefix[ADDR_W-1:0] & cur_mask;
   assign cur_match     = cur_len_ok && ((src_ff & cur_mask) == cur_net);
   assign cur_same      = (cur_net == net1_ff) && (cur_len == len1_ff);

   // Shared count unit.
   assign cnt_slot  = cnt_second_ff ? slot2_ff : slot1_ff;
   assign cnt_len   = cnt_second_ff ? len2_ff : len1_ff;
   assign cnt_cur   = (cnt_slot < SLOT_W'(PREFIX_SLOTS)) ? counts_ff[cnt_slot] : '0;
   assign cnt_inc   = cnt_cur + COUNT_W'(1);
   assign cnt_cap   = (ADDR_W'(1) << (LEN_W'(ADDR_W) - cnt_len)) - ADDR_W'(2);
   assign cnt_below = ({1'b0, cnt_cur} < cnt_cap);
   assign cnt_warn  = cnt_below && ({1'b0, cnt_inc, 1'b0} >= {1'b0, cnt_cap}) &&
                      ({1'b0, cnt_cur, 1'b0} < {1'b0, cnt_cap});
   assign cnt_new   = cnt_below ? cnt_inc : cnt_cur;

   assign mem_we = (state_ff == ST_SEARCH) &&
                   !(cmp_vld_ff && (rd_data_ff == src_ff)) &&
                   (scan_ff >= fill_ff) &&
                   (fill_ff < FILL_W'(SEEN_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seen_mem[fill_ff[SEEN_AW-1:0]] <= src_ff;
      end
      rd_data_ff <= seen_mem[scan_ff[SEEN_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         scan_ff       <= '0;
         cmp_vld_ff    <= 1'b0;
         slot_ff       <= '0;
         phase2_ff     <= 1'b0;
         cnt_second_ff <= 1'b0;
         total_ff      <= '0;
         for (int i = 0; i < PREFIX_SLOTS; i++) begin
            prefix_ff[i] <= '0;
            counts_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TOTAL) begin
               total_ff <= csr_data[SLOT_W-1:0];
            end else if (csr_index <= CSR_PREFIX_LAST) begin
               for (int i = 0; i < PREFIX_SLOTS; i++) begin
                  if (csr_index == IDX_W'(i) + CSR_PREFIX_A) begin
                     prefix_ff[i] <= csr_data;
                  end
               end
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  src_ff        <= req_tdata;
                  hit1_ff       <= 1'b0;
                  slot1_ff      <= '0;
                  count1_ff     <= '0;
                  warn1_ff      <= 1'b0;
                  hit2_ff       <= 1'b0;
                  slot2_ff      <= '0;
                  count2_ff     <= '0;
                  warn2_ff      <= 1'b0;
                  net1_ff       <= '0;
                  len1_ff       <= '0;
                  len2_ff       <= '0;
                  scan_ff       <= '0;
                  cmp_vld_ff    <= 1'b0;
                  slot_ff       <= '0;
                  phase2_ff     <= 1'b0;
                  cnt_second_ff <= 1'b0;
                  if (req_tuser != ETHER_IPV4) begin
                     status_ff <= STAT_NOT_IP;
                     state_ff  <= ST_DONE;
                  end else if ((req_tdata == '0) || (req_tdata == {ADDR_W{1'b1}})) begin
                     status_ff <= STAT_INVALID;
                     state_ff  <= ST_DONE;
                  end else begin
                     state_ff <= ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               if (cmp_vld_ff && (rd_data_ff == src_ff)) begin
                  status_ff <= STAT_DUPLICATE;
                  state_ff  <= ST_DONE;
               end else if (scan_ff >= fill_ff) begin
                  cmp_vld_ff <= 1'b0;
                  if (fill_ff >= FILL_W'(SEEN_DEPTH)) begin
                     status_ff <= STAT_FULL;
                     state_ff  <= ST_DONE;
                  end else begin
                     fill_ff  <= fill_ff + FILL_W'(1);
                     state_ff <= ST_MATCH;
                  end
               end else begin
                  cmp_vld_ff <= 1'b1;
                  scan_ff    <= scan_ff + FILL_W'(1);
               end
            end
            ST_MATCH: begin
               if (!slot_in_range) begin
                  if (!phase2_ff) begin
                     status_ff <= STAT_NO_MATCH;
                     state_ff  <= ST_DONE;
                  end else begin
                     status_ff <= STAT_COUNTED;
                     state_ff  <= ST_COUNT;
                  end
               end else if (!phase2_ff && cur_match) begin
                  hit1_ff   <= 1'b1;
                  slot1_ff  <= slot_ff;
                  net1_ff   <= cur_net;
                  len1_ff   <= cur_len;
                  phase2_ff <= 1'b1;
                  slot_ff   <= slot_ff + SLOT_W'(1);
               end else if (phase2_ff && cur_match && !cur_same) begin
                  hit2_ff   <= 1'b1;
                  slot2_ff  <= slot_ff;
                  len2_ff   <= cur_len;
                  status_ff <= STAT_COUNTED;
                  state_ff  <= ST_COUNT;
               end else begin
                  slot_ff <= slot_ff + SLOT_W'(1);
               end
            end
            ST_COUNT: begin
               counts_ff[cnt_slot] <= cnt_new;
               if (!cnt_second_ff) begin
                  count1_ff <= cnt_new;
                  warn1_ff  <= cnt_warn;
                  if (hit2_ff) begin
                     cnt_second_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end else begin
                  count2_ff <= cnt_new;
                  warn2_ff  <= cnt_warn;
                  state_ff  <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(SEEN_DEPTH))
      else $error("seen table fill beyond depth");

   a_hits_only_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status_ff != STAT_COUNTED) |-> !hit1_ff && !hit2_ff)
      else $error("slot hit reported without counted status");

   a_second_after_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hit2_ff |-> hit1_ff && (slot2_ff > slot1_ff))
      else $error("second match not after first match");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a word without leaving idle");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the IPv4 prefix utilization counter.
// A directed table and randomized frames are checked against an in-bench tally predictor.
// Depends on ipuc_pkg and ip_prefix_utilization_counter.
`timescale 1ns / 1ps

module tb_top
   import ipuc_pkg::*;
();

   localparam int HALF_PERIOD       = 6;
   localparam int RESET_CYCLES      = 11;
   localparam int SETTLE_CYCLES     = 80;
   localparam int HOLD_CYCLES       = 400;
   localparam int STALL_LIMIT       = 4000;
   localparam int WORDS_PER_SETTING = 275;
   localparam int SETTINGS          = 6;
   localparam int NEW_PER_SETTING   = 8;

   localparam logic [IDX_W-1:0] CSR_UNMAPPED = CSR_PREFIX_LAST + 1'b1;
   localparam logic [CFG_W-1:0] CFG_ONES     = {CFG_W{1'b1}};

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic               first_hit;
      logic [SLOT_W-1:0]  first_slot;
      logic [COUNT_W-1:0] first_count;
      logic               first_warn;
      logic               second_hit;
      logic [SLOT_W-1:0]  second_slot;
      logic [COUNT_W-1:0] second_count;
      logic               second_warn;
   } tally_type;

   typedef enum {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [KIND_W-1:0]  ether;
      logic [ADDR_W-1:0]  addr;
      bit                 literal;
      logic [STAT_W-1:0]  lit_status;
      logic [IDX_W-1:0]   idx;
      logic [CFG_W-1:0]   value;
   } step_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [ADDR_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]  csr_data = '0;

   // Shadow state of the block.
   logic [ADDR_W-1:0]  seen_addrs[SEEN_DEPTH];
   int                 seen_fill = 0;
   logic [COUNT_W-1:0] slot_counts[PREFIX_SLOTS];
   logic [CFG_W-1:0]   slot_regs[PREFIX_SLOTS];
   logic [2:0]         cfg_total = '0;

   tally_type pending_tallies[$];
   int        error_count = 0;
   int        send_idle = 31;
   int        recv_idle = 79;
   logic      hold_req = 1'b0;
   bit        hold_done = 1'b0;
   int        stall_cycles = 0;

   ip_prefix_utilization_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic bit addr_recorded(logic [ADDR_W-1:0] a);
      for (int k = 0; k < seen_fill; k++) begin
         if (seen_addrs[k] == a) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void slot_decode(int s, output bit ok, output logic [ADDR_W-1:0] net,
                                       output logic [ADDR_W-1:0] mask, output int len);
      len  = int'(slot_regs[s][CFG_W-1:ADDR_W]);
      ok   = (len >= int'(LEN_MIN)) && (len <= int'(LEN_MAX));
      mask = 32'hFFFF_FFFF << (32 - len);
      net  = slot_regs[s][ADDR_W-1:0] & mask;
   endfunction

   function automatic void bump_count(int s, int len, output logic [COUNT_W-1:0] cnt,
                                      output logic warn);
      longint cap;
      longint c;
      cap  = (64'd1 << (32 - len)) - 2;
      c    = longint'(slot_counts[s]);
      warn = 1'b0;
      if (c < cap) begin
         c++;
         slot_counts[s] = COUNT_W'(c);
         if (2 * c >= cap && 2 * (c - 1) < cap) warn = 1'b1;
      end
      cnt = COUNT_W'(c);
   endfunction

   function automatic tally_type predict_tally(logic [KIND_W-1:0] kind,
                                               logic [ADDR_W-1:0] addr);
      tally_type         t;
      int                active;
      int                i;
      int                j;
      int                len;
      int                len2;
      bit                ok;
      bit                found;
      logic [ADDR_W-1:0] net;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] net2;
      logic [ADDR_W-1:0] mask2;
      t = '{default: '0};
      if (kind != ETHER_IPV4) begin
         t.status = STAT_NOT_IP;
         return t;
      end
      if (addr == '0 || addr == '1) begin
         t.status = STAT_INVALID;
         return t;
      end
      if (addr_recorded(addr)) begin
         t.status = STAT_DUPLICATE;
         return t;
      end
      if (seen_fill >= SEEN_DEPTH) begin
         t.status = STAT_FULL;
         return t;
      end
      seen_addrs[seen_fill] = addr;
      seen_fill++;
      active = (int'(cfg_total) > PREFIX_SLOTS) ? PREFIX_SLOTS : int'(cfg_total);
      found  = 1'b0;
      for (i = 0; i < active; i++) begin
         slot_decode(i, ok, net, mask, len);
         if (ok && (addr & mask) == net) begin
            found = 1'b1;
            break;
         end
      end
      if (!found) begin
         t.status = STAT_NO_MATCH;
         return t;
      end
      t.status     = STAT_COUNTED;
      t.first_hit  = 1'b1;
      t.first_slot = SLOT_W'(i);
      bump_count(i, len, t.first_count, t.first_warn);
      for (j = i + 1; j < active; j++) begin
         slot_decode(j, ok, net2, mask2, len2);
         if (!ok) continue;
         if (net2 == net && len2 == len) continue;
         if ((addr & mask2) == net2) begin
            t.second_hit  = 1'b1;
            t.second_slot = SLOT_W'(j);
            bump_count(j, len2, t.second_count, t.second_warn);
            break;
         end
      end
      return t;
   endfunction

   function automatic void apply_csr(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CSR_TOTAL) begin
         cfg_total = value[2:0];
      end else if (idx >= CSR_PREFIX_A && idx <= CSR_PREFIX_LAST) begin
         slot_regs[idx - CSR_PREFIX_A] = value;
      end
   endfunction

   function automatic step_row_type word_row(logic [KIND_W-1:0] ether,
                                             logic [ADDR_W-1:0] addr,
                                             bit literal, logic [STAT_W-1:0] st);
      step_row_type r;
      r = '{kind: ROW_WORD, ether: ether, addr: addr, literal: literal, lit_status: st,
            idx: '0, value: '0};
      return r;
   endfunction

   function automatic step_row_type csr_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      step_row_type r;
      r = '{kind: ROW_CSR, ether: '0, addr: '0, literal: 1'b0, lit_status: '0,
            idx: idx, value: value};
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] prefix_value(int len, logic [ADDR_W-1:0] base);
      return {LEN_W'(len), base};
   endfunction

   task automatic send_word(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                            bit literal, logic [STAT_W-1:0] st);
      tally_type t;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= addr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      t = predict_tally(kind, addr);
      if (literal) begin
         t        = '{default: '0};
         t.status = st;
      end
      pending_tallies.push_back(t);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, value);
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_tallies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_random_setting(int k);
      logic [2:0]        total;
      logic [ADDR_W-1:0] base;
      int                len;
      int                r;
      case (k)
         0: total = 3'(PREFIX_SLOTS);
         1: total = 3'd0;
         3: total = 3'd7;
         5: total = 3'(PREFIX_SLOTS);
         default: total = 3'($urandom_range(1, PREFIX_SLOTS));
      endcase
      write_csr(CSR_TOTAL, CFG_W'(total));
      for (int s = 0; s < PREFIX_SLOTS; s++) begin
         r    = $urandom_range(0, 99);
         base = $urandom();
         if (r < 8) begin
            len = $urandom_range(0, 1) ? 0 : $urandom_range(31, 63);
         end else if (r < 48 && s > 0) begin
            base = slot_regs[$urandom_range(0, s - 1)][ADDR_W-1:0];
            len  = $urandom_range(20, 30);
         end else begin
            len = (r < 90) ? $urandom_range(25, 30) : $urandom_range(1, 24);
         end
         write_csr(CSR_PREFIX_A + IDX_W'(s), (k == 1) ? CFG_ONES : prefix_value(len, base));
      end
      write_csr(CSR_UNMAPPED, CFG_W'({$urandom(), $urandom()}));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ADDR_W-1:0] fresh_source();
      int                r;
      int                s;
      int                len;
      logic [ADDR_W-1:0] mask;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         s   = $urandom_range(0, PREFIX_SLOTS - 1);
         len = int'(slot_regs[s][CFG_W-1:ADDR_W]);
         if (len < int'(LEN_MIN) || len > int'(LEN_MAX)) return $urandom();
         mask = 32'hFFFF_FFFF << (32 - len);
         return (slot_regs[s][ADDR_W-1:0] & mask) | ($urandom() & ~mask);
      end
      if (r < 85 && seen_fill > 0) return seen_addrs[$urandom_range(0, seen_fill - 1)];
      return $urandom();
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      tally_type got;
      tally_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status       = rsp_tuser;
         got.first_hit    = rsp_tdata[0];
         got.first_slot   = rsp_tdata[3:1];
         got.first_count  = rsp_tdata[34:4];
         got.first_warn   = rsp_tdata[35];
         got.second_hit   = rsp_tdata[36];
         got.second_slot  = rsp_tdata[39:37];
         got.second_count = rsp_tdata[70:40];
         got.second_warn  = rsp_tdata[71];
         if (pending_tallies.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none, actual status %0d data %0h",
                     $time, got.status, rsp_tdata);
         end else begin
            want = pending_tallies.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("first_hit", 32'(want.first_hit), 32'(got.first_hit));
            check_field("first_slot", 32'(want.first_slot), 32'(got.first_slot));
            check_field("first_count", 32'(want.first_count), 32'(got.first_count));
            check_field("first_half_warn", 32'(want.first_warn), 32'(got.first_warn));
            check_field("second_hit", 32'(want.second_hit), 32'(got.second_hit));
            check_field("second_slot", 32'(want.second_slot), 32'(got.second_slot));
            check_field("second_count", 32'(want.second_count), 32'(got.second_count));
            check_field("second_half_warn", 32'(want.second_warn), 32'(got.second_warn));
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      step_row_type      rows[];
      bit                csr_open;
      int                budget;
      int                counted;
      int                r;
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] addr;

      for (int s = 0; s < PREFIX_SLOTS; s++) begin
         slot_counts[s] = '0;
         slot_regs[s]   = '0;
      end
      rows = {
         word_row(ETHER_IPV4, 32'h0A00_0001, 1'b1, STAT_NO_MATCH),
         word_row(16'h0000,   32'h1234_5678, 1'b1, STAT_NOT_IP),
         word_row(16'hFFFF,   32'hFFFF_FFFF, 1'b1, STAT_NOT_IP),
         word_row(16'h0801,   32'h0A00_0002, 1'b1, STAT_NOT_IP),
         word_row(ETHER_IPV4, 32'h0000_0000, 1'b1, STAT_INVALID),
         word_row(ETHER_IPV4, 32'hFFFF_FFFF, 1'b1, STAT_INVALID),
         word_row(ETHER_IPV4, 32'h0A00_0001, 1'b1, STAT_DUPLICATE),
         csr_row(CSR_TOTAL, 38'd7),
         csr_row(CSR_PREFIX_A,         prefix_value(30, 32'hC0A8_0103)),
         csr_row(CSR_PREFIX_A + 3'd1, '0),
         csr_row(CSR_PREFIX_A + 3'd2, prefix_value(30, 32'hC0A8_0100)),
         csr_row(CSR_PREFIX_A + 3'd3, prefix_value(16, 32'hC0A8_0000)),
         csr_row(CSR_PREFIX_A + 3'd4, CFG_ONES),
         csr_row(CSR_PREFIX_LAST,      prefix_value(1, 32'h0B00_0000)),
         csr_row(CSR_UNMAPPED, CFG_ONES),
         word_row(ETHER_IPV4, 32'hC0A8_0101, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'hC0A8_0102, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'hC0A8_0100, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'hC0A8_0103, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'hC0A8_0101, 1'b1, STAT_DUPLICATE),
         word_row(ETHER_IPV4, 32'h0506_0708, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'hC0A9_0000, 1'b1, STAT_NO_MATCH),
         word_row(ETHER_IPV4, 32'h7FFF_FFFF, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'h8000_0000, 1'b1, STAT_NO_MATCH),
         word_row(ETHER_IPV4, 32'hFFFF_FFFE, 1'b1, STAT_NO_MATCH),
         word_row(ETHER_IPV4, 32'h0000_0001, 1'b0, STAT_COUNTED),
         csr_row(CSR_TOTAL, 38'd1),
         csr_row(CSR_PREFIX_A, prefix_value(29, 32'h0102_0300)),
         word_row(ETHER_IPV4, 32'h0102_0301, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'h0102_0302, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'h0102_0303, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'h0102_0304, 1'b0, STAT_COUNTED),
         word_row(ETHER_IPV4, 32'h0102_0305, 1'b0, STAT_COUNTED)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_open = 1'b0;
      foreach (rows[n]) begin
         if (rows[n].kind == ROW_CSR) begin
            if (!csr_open) drain_block();
            write_csr(rows[n].idx, rows[n].value);
            csr_open = 1'b1;
         end else begin
            if (csr_open) csr_valid <= 1'b0;
            csr_open = 1'b0;
            send_word(rows[n].ether, rows[n].addr, rows[n].literal, rows[n].lit_status);
         end
      end

      for (int k = 0; k < SETTINGS; k++) begin
         drain_block();
         load_random_setting(k);
         case (k / 2)
            0: begin send_idle = 31; recv_idle = 79; end
            1: begin send_idle = 79; recv_idle = 31; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         budget  = NEW_PER_SETTING;
         counted = 0;
         while (counted < WORDS_PER_SETTING) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               kind = KIND_W'($urandom_range(0, 16'hFFFF));
               addr = $urandom();
            end else if (r < 14) begin
               kind = ETHER_IPV4;
               addr = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            end else begin
               kind = ETHER_IPV4;
               addr = fresh_source();
               if (addr != '0 && addr != '1 && !addr_recorded(addr) &&
                   seen_fill < SEEN_DEPTH) begin
                  if (budget == 0 && k < SETTINGS - 1)
                     addr = seen_addrs[$urandom_range(0, seen_fill - 1)];
                  else
                     budget--;
               end
            end
            if (k == 2 && counted == 40) hold_req <= 1'b1;
            send_word(kind, addr, 1'b0, STAT_NOT_IP);
            counted++;
         end
      end

      drain_block();
      if (error_count == 0 && pending_tallies.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
